@@ rtl/core/lcom_pkg.sv @@
package lcom_pkg;

  // Field widths
  localparam int RANGE_W   = 16;
  localparam int COL_W     = 12;
  localparam int RATIO_W   = 8;
  localparam int CURV_W    = 39;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  // Window geometry
  localparam int WIN  = 17;  // slots in the point chain
  localparam int LAG  = 11;  // slot a point is emitted from
  localparam int EDGE = 5;   // neighbors needed on each side for curvature

  // Running sum over slots LAG-EDGE .. WIN-1 (eleven ranges)
  localparam int SUM_W = 20;
  localparam int ABS_W = 20;

  // Scan counter and flush counter share a width; both top out at LAG
  localparam int CNT_W       = 4;
  localparam int FLUSH_STEPS = LAG;

  // Slots touched by the pair test (after the shift)
  localparam int OCCL_NEAR_HI = 5;
  localparam int OCCL_FAR_HI  = 11;
  localparam int PAR_SLOT     = 6;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OCCL_GAP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COL_GAP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAR_RATIO = 2'd2;

  // Register reset values
  localparam logic [RANGE_W-1:0] OCCL_GAP_RST  = 16'd77;
  localparam logic [COL_W-1:0]   COL_GAP_RST   = 12'd10;
  localparam logic [RATIO_W-1:0] PAR_RATIO_RST = 8'd5;

  // One slot of the chain
  typedef struct packed {
    logic [RANGE_W-1:0] range;
    logic               occ;      // slot holds a point, not a bubble
    logic               head_ok;  // at least EDGE points before it in its scan
    logic               last;     // final point of its scan
    logic               mark;     // occluded or parallel beam
  } cell_t;

  // Marks raised by one pair test
  typedef struct packed {
    logic occl_far;
    logic occl_near;
    logic par;
  } pair_marks_t;

  // Point leaving the chain toward the curvature pipe
  typedef struct packed {
    logic               occ;
    logic               curv_ok;
    logic               mark;
    logic               last;
    logic [RANGE_W-1:0] center;
  } emit_t;

endpackage

@@ rtl/core/lidar_curvature_occlusion_marker.sv @@
// Channel  | Handshake             | Payload
// ---------+-----------------------+------------------------------------------------
// in       | in_valid / in_ready   | in_range_in, in_column_in, in_last_point
// out      | out_valid / out_ready | out_curvature, out_curvature_valid,
//          |                       | out_picked_mark, out_last_result
// cfg      | cfg_we (no wait)      | cfg_index, cfg_wdata
//
// One request per cycle while streaming and not stalled. The request that pushes a
// point to slot 11 also loads its diff stage; the square stage then registers the result.
// A request with in_last_point set is followed by a flush with in_ready low:
// the chain keeps shifting bubbles until the last point reaches slot 11.
// Reset (rst_n low, synchronous) empties the chain and loads register defaults.
// A stall on out_ready freezes the chain, the pipe and in_ready together.
module lidar_curvature_occlusion_marker #(
  parameter int MAX_COLUMNS = 4096
) (
  input  logic                            clk,
  input  logic                            rst_n,

  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [lcom_pkg::RANGE_W-1:0]    in_range_in,
  input  logic [lcom_pkg::COL_W-1:0]      in_column_in,
  input  logic                            in_last_point,

  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [lcom_pkg::CURV_W-1:0]     out_curvature,
  output logic                            out_curvature_valid,
  output logic                            out_picked_mark,
  output logic                            out_last_result,

  input  logic                            cfg_we,
  input  logic [lcom_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lcom_pkg::CFG_W-1:0]      cfg_wdata
);

  // Stored columns are clamped below MAX_COLUMNS, so this many bits hold them.
  localparam int COLUMN_W = $clog2(MAX_COLUMNS);
  localparam int WIN      = lcom_pkg::WIN;
  localparam int CNT_W    = lcom_pkg::CNT_W;

  // Pre-shift slots feeding the pair test and the emitted point.
  localparam int FAR_SLOT  = lcom_pkg::PAR_SLOT;
  localparam int MID_SLOT  = lcom_pkg::PAR_SLOT - 1;
  localparam int NEAR_SLOT = lcom_pkg::PAR_SLOT - 2;
  localparam int EMIT_SLOT = lcom_pkg::LAG - 1;
  localparam int ADD_SLOT  = lcom_pkg::LAG - lcom_pkg::EDGE - 1;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [lcom_pkg::RANGE_W-1:0] occl_gap_r;
  logic [lcom_pkg::COL_W-1:0]   col_gap_r;
  logic [lcom_pkg::RATIO_W-1:0] par_ratio_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occl_gap_r  <= lcom_pkg::OCCL_GAP_RST;
      col_gap_r   <= lcom_pkg::COL_GAP_RST;
      par_ratio_r <= lcom_pkg::PAR_RATIO_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        lcom_pkg::REG_OCCL_GAP:  occl_gap_r  <= cfg_wdata[lcom_pkg::RANGE_W-1:0];
        lcom_pkg::REG_COL_GAP:   col_gap_r   <= cfg_wdata[lcom_pkg::COL_W-1:0];
        lcom_pkg::REG_PAR_RATIO: par_ratio_r <= cfg_wdata[lcom_pkg::RATIO_W-1:0];
        default: ;  // unknown index: write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control
  // ---------------------------------------------------------------------------
  logic             advance;      // result pipe can move
  logic             accept;
  logic             flush_step;
  logic             shift;
  logic [CNT_W-1:0] count_r, count_nxt;      // points of this scan, saturates at LAG
  logic [CNT_W-1:0] flush_cnt_r, flush_cnt_nxt;

  assign in_ready   = advance && (flush_cnt_r == '0);
  assign accept     = in_valid && in_ready;
  assign flush_step = (flush_cnt_r != '0) && advance;
  assign shift      = accept || flush_step;

  always_comb begin
    count_nxt = count_r;
    if (accept) begin
      if (in_last_point) begin
        count_nxt = '0;
      end else if (count_r < CNT_W'(lcom_pkg::LAG)) begin
        count_nxt = count_r + 1'b1;
      end
    end
  end

  always_comb begin
    flush_cnt_nxt = flush_cnt_r;
    if (accept && in_last_point) begin
      flush_cnt_nxt = CNT_W'(lcom_pkg::FLUSH_STEPS);
    end else if (flush_step) begin
      flush_cnt_nxt = flush_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      flush_cnt_r <= '0;
    end else begin
      count_r     <= count_nxt;
      flush_cnt_r <= flush_cnt_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Point chain: slot 0 newest; bubbles enter during a flush
  // ---------------------------------------------------------------------------
  logic [COLUMN_W-1:0]   col_clamped;
  lcom_pkg::cell_t       head;
  lcom_pkg::cell_t       cell_q [WIN];
  logic [COLUMN_W-1:0]   col_q  [WIN];
  logic [WIN-1:0]        set_mark;
  lcom_pkg::pair_marks_t pm;

  assign col_clamped = ({1'b0, in_column_in} >= (lcom_pkg::COL_W + 1)'(MAX_COLUMNS))
                     ? COLUMN_W'(MAX_COLUMNS - 1) : in_column_in[COLUMN_W-1:0];

  always_comb begin
    head = '0;
    if (accept) begin
      head.range   = in_range_in;
      head.occ     = 1'b1;
      head.head_ok = count_r >= CNT_W'(lcom_pkg::EDGE);
      head.last    = in_last_point;
    end
  end

  for (genvar i = 0; i < WIN; i++) begin : g_cell
    if (i <= lcom_pkg::OCCL_NEAR_HI) begin : g_near
      assign set_mark[i] = pm.occl_near;
    end else if (i <= lcom_pkg::OCCL_FAR_HI) begin : g_far
      assign set_mark[i] = pm.occl_far | ((i == lcom_pkg::PAR_SLOT) ? pm.par : 1'b0);
    end else begin : g_tail
      assign set_mark[i] = 1'b0;
    end

    if (i == 0) begin : g_head
      lcom_cell #(.COLUMN_W(COLUMN_W)) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift    (shift),
        .set_mark (set_mark[i]),
        .d_in     (head),
        .col_in   (col_clamped),
        .q        (cell_q[i]),
        .col_q    (col_q[i])
      );
    end else begin : g_body
      lcom_cell #(.COLUMN_W(COLUMN_W)) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift    (shift),
        .set_mark (set_mark[i]),
        .d_in     (cell_q[i-1]),
        .col_in   (col_q[i-1]),
        .q        (cell_q[i]),
        .col_q    (col_q[i])
      );
    end
  end

  // Pair test: runs on a request once eleven points of the scan precede it.
  // Marks land in the same edge as the shift.
  lcom_pair_test #(.COLUMN_W(COLUMN_W)) u_pair (
    .test_en    (accept && (count_r == CNT_W'(lcom_pkg::LAG))),
    .range_far  (cell_q[FAR_SLOT].range),
    .range_mid  (cell_q[MID_SLOT].range),
    .range_near (cell_q[NEAR_SLOT].range),
    .col_mid    (col_q[MID_SLOT]),
    .col_near   (col_q[NEAR_SLOT]),
    .occl_gap   (occl_gap_r),
    .col_gap    (col_gap_r),
    .par_ratio  (par_ratio_r),
    .marks      (pm)
  );

  // ---------------------------------------------------------------------------
  // Point moving into slot 11: curvature is valid when it has five scan
  // points behind it (head_ok) and five real points ahead (slot 6 occupied).
  // ---------------------------------------------------------------------------
  lcom_pkg::emit_t entry;

  always_comb begin
    entry.occ     = cell_q[EMIT_SLOT].occ;
    entry.curv_ok = cell_q[EMIT_SLOT].head_ok && cell_q[ADD_SLOT].occ;
    entry.mark    = cell_q[EMIT_SLOT].mark | pm.occl_far;
    entry.last    = cell_q[EMIT_SLOT].last;
    entry.center  = cell_q[EMIT_SLOT].range;
  end

  lcom_curv u_curv (
    .clk                 (clk),
    .rst_n               (rst_n),
    .shift               (shift),
    .entry               (entry),
    .add_range           (cell_q[ADD_SLOT].range),
    .drop_range          (cell_q[WIN-1].range),
    .advance             (advance),
    .out_ready           (out_ready),
    .out_valid           (out_valid),
    .out_curvature       (out_curvature),
    .out_curvature_valid (out_curvature_valid),
    .out_picked_mark     (out_picked_mark),
    .out_last_result     (out_last_result)
  );

`ifndef SYNTHESIS
  a_flush_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_last_point) |=> !in_ready)
    else $error("request taken during flush");

  a_marks_need_full_window: assert property (@(posedge clk) disable iff (!rst_n)
    (pm.occl_far || pm.occl_near || pm.par) |-> (accept && count_r == CNT_W'(lcom_pkg::LAG)))
    else $error("pair mark raised without a full window");
`endif

endmodule

@@ rtl/core/lcom_cell.sv @@
module lcom_cell #(
  parameter int COLUMN_W = 12
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 shift,
  input  logic                 set_mark,
  input  lcom_pkg::cell_t      d_in,
  input  logic [COLUMN_W-1:0]  col_in,
  output lcom_pkg::cell_t      q,
  output logic [COLUMN_W-1:0]  col_q
);

  lcom_pkg::cell_t     cell_r;
  lcom_pkg::cell_t     cell_nxt;
  logic [COLUMN_W-1:0] col_r;

  always_comb begin
    cell_nxt      = d_in;
    cell_nxt.mark = d_in.mark | set_mark;
  end

  // Range resets too: the running neighbor sum downstream relies on it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r <= '0;
    end else if (shift) begin
      cell_r <= cell_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      col_r <= col_in;
    end
  end

  assign q     = cell_r;
  assign col_q = col_r;

endmodule

@@ rtl/core/lcom_pair_test.sv @@
module lcom_pair_test #(
  parameter int COLUMN_W = 12
) (
  input  logic                          test_en,
  input  logic [lcom_pkg::RANGE_W-1:0]  range_far,
  input  logic [lcom_pkg::RANGE_W-1:0]  range_mid,
  input  logic [lcom_pkg::RANGE_W-1:0]  range_near,
  input  logic [COLUMN_W-1:0]           col_mid,
  input  logic [COLUMN_W-1:0]           col_near,
  input  logic [lcom_pkg::RANGE_W-1:0]  occl_gap,
  input  logic [lcom_pkg::COL_W-1:0]    col_gap,
  input  logic [lcom_pkg::RATIO_W-1:0]  par_ratio,
  output lcom_pkg::pair_marks_t         marks
);

  localparam int XW  = lcom_pkg::RANGE_W + 1;
  localparam int LIMW = lcom_pkg::RANGE_W + lcom_pkg::RATIO_W;

  logic [COLUMN_W-1:0]          col_dist;
  logic                         close;
  logic [XW-1:0]                mid_x, near_x, gap_x;
  logic                         step_far, step_near;
  logic [lcom_pkg::RANGE_W-1:0] p1, p2;
  logic [LIMW-1:0]              lim;
  logic                         par_hit;

  assign col_dist = (col_near >= col_mid) ? (col_near - col_mid) : (col_mid - col_near);
  assign close    = lcom_pkg::COL_W'(col_dist) < col_gap;

  assign mid_x  = {1'b0, range_mid};
  assign near_x = {1'b0, range_near};
  assign gap_x  = {1'b0, occl_gap};

  // Mid point farther than the nearer neighbor: the far side is hidden.
  assign step_far  = mid_x > (near_x + gap_x);
  assign step_near = near_x > (mid_x + gap_x);

  assign p1  = (range_far >= range_mid) ? (range_far - range_mid) : (range_mid - range_far);
  assign p2  = (range_near >= range_mid) ? (range_near - range_mid) : (range_mid - range_near);
  assign lim = LIMW'(par_ratio) * LIMW'(range_mid);

  assign par_hit = ({p1, 8'd0} > lim) && ({p2, 8'd0} > lim);

  assign marks.occl_far  = test_en && close && step_far;
  assign marks.occl_near = test_en && close && !step_far && step_near;
  assign marks.par       = test_en && par_hit;

endmodule

@@ rtl/core/lcom_curv.sv @@
module lcom_curv (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          shift,
  input  lcom_pkg::emit_t               entry,
  input  logic [lcom_pkg::RANGE_W-1:0]  add_range,
  input  logic [lcom_pkg::RANGE_W-1:0]  drop_range,
  output logic                          advance,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [lcom_pkg::CURV_W-1:0]   out_curvature,
  output logic                          out_curvature_valid,
  output logic                          out_picked_mark,
  output logic                          out_last_result
);

  localparam int SUM_W  = lcom_pkg::SUM_W;
  localparam int ABS_W  = lcom_pkg::ABS_W;
  localparam int DIFF_W = SUM_W + 2;
  localparam int SQ_W   = 2 * ABS_W;

  logic [SUM_W-1:0]  win_sum_r, win_sum_nxt;
  logic [DIFF_W-1:0] center11, diff;
  logic [ABS_W-1:0]  abs_nxt;

  logic              s1_valid_r;
  logic [ABS_W-1:0]  s1_abs_r;
  logic              s1_ok_r, s1_mark_r, s1_last_r;

  logic              out_valid_r;
  logic [lcom_pkg::CURV_W-1:0] curv_r;
  logic              curv_ok_r, mark_r, last_r;
  logic [SQ_W-1:0]   sq;

  assign advance = !out_valid_r || out_ready;

  // Sum of eleven ranges around the emitted slot, kept as the chain moves
  assign win_sum_nxt = win_sum_r + SUM_W'(add_range) - SUM_W'(drop_range);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_sum_r <= '0;
    end else if (shift) begin
      win_sum_r <= win_sum_nxt;
    end
  end

  // sum of ten neighbors - 10*center = sum of eleven - 11*center
  assign center11 = {entry.center, 3'b000} + {entry.center, 1'b0} + DIFF_W'(entry.center);
  assign diff     = DIFF_W'(win_sum_nxt) - center11;
  assign abs_nxt  = diff[DIFF_W-1] ? ABS_W'(-diff) : diff[ABS_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r  <= shift && entry.occ;
      out_valid_r <= s1_valid_r;
    end
  end

  assign sq = SQ_W'(s1_abs_r) * SQ_W'(s1_abs_r);

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_abs_r  <= abs_nxt;
      s1_ok_r   <= entry.curv_ok;
      s1_mark_r <= entry.mark;
      s1_last_r <= entry.last;
      curv_r    <= s1_ok_r ? sq[lcom_pkg::CURV_W-1:0] : '0;
      curv_ok_r <= s1_ok_r;
      mark_r    <= s1_mark_r;
      last_r    <= s1_last_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_curvature       = curv_r;
  assign out_curvature_valid = curv_ok_r;
  assign out_picked_mark     = mark_r;
  assign out_last_result     = last_r;

`ifndef SYNTHESIS
  a_shift_only_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
    shift |-> advance)
    else $error("chain moved while result pipe stalled");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_valid_r) |=> out_valid_r)
    else $error("pending result lost between stages");
`endif

endmodule

@@ tb/lidar_curvature_occlusion_marker_tb.sv @@
module lidar_curvature_occlusion_marker_tb;
  import lcom_pkg::*;

  // Test bench knobs
  localparam int unsigned MAX_POINTS    = 65536;         // scan counter saturates one below
  localparam int unsigned LONG_SCAN_LEN = MAX_POINTS + 4; // runs past the saturation point
  localparam int          SETTLE_CYCLES = 16;            // pipe depth plus flush, with margin
  localparam int          STALL_LIMIT   = 2000;          // cycles without any request moving
  localparam int          HOLD_CYCLES   = 300;           // long receiver hold-off
  localparam int          REPORT_CAP    = 40;            // mismatch lines printed at most

  // Index 3 decodes to no register; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // One emitted point, field for field as it leaves the block
  typedef struct packed {
    logic [CURV_W-1:0] curvature;
    logic              curv_valid;
    logic              mark;
    logic              last;
  } point_result_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [RANGE_W-1:0]   in_range_in;
  logic [COL_W-1:0]     in_column_in;
  logic                 in_last_point;
  logic                 out_valid;
  logic                 out_ready;
  logic [CURV_W-1:0]    out_curvature;
  logic                 out_curvature_valid;
  logic                 out_picked_mark;
  logic                 out_last_result;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  lidar_curvature_occlusion_marker i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_range_in         (in_range_in),
    .in_column_in        (in_column_in),
    .in_last_point       (in_last_point),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_curvature       (out_curvature),
    .out_curvature_valid (out_curvature_valid),
    .out_picked_mark     (out_picked_mark),
    .out_last_result     (out_last_result),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  // Predictor state: point window (slot 0 newest), marks, scan count, registers
  bit [RANGE_W-1:0] rng_win  [WIN];
  bit [COL_W-1:0]   col_win  [WIN];
  bit               mark_win [WIN];
  int unsigned      pts_seen;
  bit [RANGE_W-1:0] occl_gap    = OCCL_GAP_RST;
  bit [COL_W-1:0]   col_gap_lim = COL_GAP_RST;
  bit [RATIO_W-1:0] par_ratio   = PAR_RATIO_RST;

  // Points still owed by the block, oldest first
  point_result_t expected_points [$];

  // Run bookkeeping
  int mismatches;
  int results_seen;
  int points_sent;
  int scans_sent;
  int settings_used;
  int idle_cycles;

  // Idling controls shared by the sender task and the receiver process
  bit tx_gaps = 1'b1;
  bit rx_gaps = 1'b1;
  int hold_left;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Squared deviation of a slot from its ten neighbors, kept to the port width
  function automatic logic [CURV_W-1:0] curvature_of(int slot);
    longint acc;
    acc = 0;
    for (int k = slot - EDGE; k <= slot + EDGE; k++) begin
      if (k != slot) acc += longint'(rng_win[k]);
    end
    acc -= 10 * longint'(rng_win[slot]);
    if (acc < 0) acc = -acc;
    return CURV_W'(acc * acc);
  endfunction

  function automatic void queue_result(int slot, int unsigned seen, bit is_last);
    point_result_t res;
    // curvature only counts with five real neighbors on both sides
    res.curv_valid = (slot >= EDGE) && (seen >= slot + EDGE) && (slot + EDGE < WIN);
    res.curvature  = res.curv_valid ? curvature_of(slot) : '0;
    res.mark       = mark_win[slot];
    res.last       = is_last;
    expected_points.push_back(res);
  endfunction

  // Shift one accepted point in, run the pair tests, queue what leaves
  function automatic void predict_point(logic [RANGE_W-1:0] rng, logic [COL_W-1:0] col,
                                        bit is_last);
    int unsigned seen;
    longint      older_r, newer_r, col_diff, step_prev, step_next, thresh;
    int          slot;
    seen = pts_seen;
    for (int k = WIN - 1; k > 0; k--) begin
      rng_win[k]  = rng_win[k-1];
      col_win[k]  = col_win[k-1];
      mark_win[k] = mark_win[k-1];
    end
    rng_win[0]  = rng;
    col_win[0]  = col;
    mark_win[0] = 1'b0;
    if (pts_seen < MAX_POINTS - 1) pts_seen++;

    if (seen >= LAG) begin
      // pair under test: older point in PAR_SLOT, newer one just ahead of it
      older_r  = longint'(rng_win[PAR_SLOT]);
      newer_r  = longint'(rng_win[OCCL_NEAR_HI]);
      col_diff = longint'(col_win[OCCL_NEAR_HI]) - longint'(col_win[PAR_SLOT]);
      if (col_diff < 0) col_diff = -col_diff;
      if (col_diff < longint'(col_gap_lim)) begin
        if (older_r - newer_r > longint'(occl_gap)) begin
          for (int k = PAR_SLOT; k <= OCCL_FAR_HI; k++) mark_win[k] = 1'b1;
        end else if (newer_r - older_r > longint'(occl_gap)) begin
          for (int k = 0; k <= OCCL_NEAR_HI; k++) mark_win[k] = 1'b1;
        end
      end
      // parallel beam: both neighbor steps above ratio/256 of own range
      step_prev = longint'(rng_win[PAR_SLOT+1]) - older_r;
      step_next = newer_r - older_r;
      if (step_prev < 0) step_prev = -step_prev;
      if (step_next < 0) step_next = -step_next;
      thresh = longint'(par_ratio) * older_r;
      if (step_prev * 256 > thresh && step_next * 256 > thresh) mark_win[PAR_SLOT] = 1'b1;
    end

    if (!is_last) begin
      if (seen >= LAG) queue_result(LAG, seen, 1'b0);
    end else begin
      // flush: everything still held, oldest first
      slot = (seen >= LAG) ? LAG : int'(seen);
      for (; slot >= 0; slot--) queue_result(slot, seen, slot == 0);
      pts_seen = 0;
      for (int k = 0; k < WIN; k++) mark_win[k] = 1'b0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // One point request; valid stays up after acceptance so streams run back to back
  task automatic send_point(logic [RANGE_W-1:0] rng, logic [COL_W-1:0] col, bit is_last);
    if (tx_gaps && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_range_in   <= rng;
    in_column_in  <= col;
    in_last_point <= is_last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_point(rng, col, is_last);
    points_sent++;
    if (is_last) scans_sent++;
  endtask

  // Drop valid, let every owed result come out, then give the pipe time to settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // cfg_we is left high between back-to-back writes; the caller lowers it
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      REG_OCCL_GAP:  occl_gap    = data;
      REG_COL_GAP:   col_gap_lim = data[COL_W-1:0];
      REG_PAR_RATIO: par_ratio   = data[RATIO_W-1:0];
      default: ;
    endcase
  endtask

  // Only called with the block drained. Unused upper data bits carry junk on purpose.
  task automatic set_config(logic [CFG_W-1:0] gap, logic [COL_W-1:0] cols,
                            logic [RATIO_W-1:0] ratio);
    write_reg(REG_UNUSED, CFG_W'($urandom));
    write_reg(REG_OCCL_GAP, gap);
    write_reg(REG_COL_GAP, {(CFG_W-COL_W)'($urandom), cols});
    write_reg(REG_PAR_RATIO, {(CFG_W-RATIO_W)'($urandom), ratio});
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Surface-like scan: random walk in range with steps and lone spikes,
  // columns mostly creeping forward with the odd jump
  task automatic run_random_scan(int unsigned len, bit closes_scan);
    int level, rng, col;
    level = $urandom_range(0, 65535);
    col   = $urandom_range(0, 4095);
    for (int unsigned k = 0; k < len; k++) begin
      case ($urandom_range(0, 15))
        0:       level = $urandom_range(0, 65535);
        1, 2:    level = level + int'($urandom_range(0, 4000)) - 2000;
        default: level = level + int'($urandom_range(0, 16)) - 8;
      endcase
      if (level < 0) level = 0;
      else if (level > 65535) level = 65535;
      rng = level;
      if ($urandom_range(0, 11) == 0) rng = $urandom_range(0, 65535);
      if ($urandom_range(0, 9) == 0) col = $urandom_range(0, 4095);
      else col = (col + int'($urandom_range(0, 3))) % 4096;
      send_point(rng[RANGE_W-1:0], col[COL_W-1:0], closes_scan && (k == len - 1));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Hand-built scans at reset settings: lone point, a profile with a step up,
  // a step down and a spike, and a short all-zero scan.
  task automatic test_directed_scans();
    int unsigned profile [17] = '{0, 65535, 500, 500, 500, 500, 3000, 1000, 1000, 1000,
                                  4000, 4000, 4000, 4000, 200, 4000, 65535};
    // single point scan: max range, max column, one result out of the flush
    send_point('1, '1, 1'b1);
    // 17 points: occlusion both ways plus a parallel beam on the 3000 point
    for (int k = 0; k < 17; k++) begin
      send_point(profile[k][RANGE_W-1:0], (k == 0) ? '1 : COL_W'(k), k == 16);
    end
    // too short for any curvature
    for (int k = 0; k < 5; k++) send_point('0, '0, k == 4);
    wait_drained();
  endtask

  // Extremes of every register, then a random setting, then back to defaults
  task automatic test_register_settings();
    for (int round = 0; round < 5; round++) begin
      case (round)
        0: set_config('0, '0, '0);
        1: set_config('1, '1, '1);
        2: set_config('0, '1, '0);
        3: set_config($urandom_range(0, 2000), $urandom_range(1, 64), $urandom_range(1, 40));
        default: set_config(OCCL_GAP_RST, COL_GAP_RST, PAR_RATIO_RST);
      endcase
      repeat (2) run_random_scan($urandom_range(12, 30), 1'b1);
      wait_drained();
    end
  endtask

  // Bulk random scans; short ones hit the flush corners, long ones stream
  task automatic test_random_scans();
    int start;
    start = points_sent;
    while (points_sent - start < 250) begin
      run_random_scan(($urandom_range(0, 3) == 0) ? $urandom_range(1, 12)
                                                   : $urandom_range(13, 45), 1'b1);
    end
    wait_drained();
  endtask

  // Receiver holds off while the sender keeps pushing: block must fill and stall
  task automatic test_output_backpressure();
    tx_gaps   = 1'b0;
    hold_left = HOLD_CYCLES;
    run_random_scan(80, 1'b1);
    wait_drained();
    tx_gaps = 1'b1;
  endtask

  // Sender stops mid-scan until nothing is owed, then finishes the scan
  task automatic test_sender_pause();
    repeat (3) begin
      run_random_scan($urandom_range(3, 30), 1'b0);
      wait_drained();
      run_random_scan($urandom_range(1, 25), 1'b1);
      wait_drained();
    end
  endtask

  // Past the scan counter's saturation, full rate, no idling anywhere
  task automatic test_long_scan();
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    run_random_scan(LONG_SCAN_LEN, 1'b1);
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Receiver, checker, watchdog
  // ---------------------------------------------------------------------------

  // out_ready: long hold when asked, always high with rx_gaps off, else random stall bursts between free runs
  initial begin : receiver
    int stall_left, free_left;
    stall_left = 0;
    free_left  = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!rx_gaps) begin
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (free_left > 0) begin
        free_left--;
        out_ready <= 1'b1;
      end else begin
        stall_left = $urandom_range(1, 16);
        free_left  = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
        out_ready <= 1'b1;
      end
    end
  end

  task automatic report_mismatch(string what);
    if (mismatches < REPORT_CAP) $display("MISMATCH at result %0d: %s", results_seen, what);
    mismatches++;
  endtask

  always @(posedge clk) begin : check_results
    point_result_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got.curvature  = out_curvature;
      got.curv_valid = out_curvature_valid;
      got.mark       = out_picked_mark;
      got.last       = out_last_result;
      if (expected_points.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        want = expected_points.pop_front();
        if (got.curvature !== want.curvature)
          report_mismatch($sformatf("curvature %0d, expected %0d",
                                    got.curvature, want.curvature));
        if (got.curv_valid !== want.curv_valid)
          report_mismatch($sformatf("curvature_valid %b, expected %b",
                                    got.curv_valid, want.curv_valid));
        if (got.mark !== want.mark)
          report_mismatch($sformatf("picked_mark %b, expected %b", got.mark, want.mark));
        if (got.last !== want.last)
          report_mismatch($sformatf("last_result %b, expected %b", got.last, want.last));
      end
      results_seen++;
    end
  end

  // Any request moving on either side resets the count
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("TIMEOUT: no request moved for %0d cycles, %0d results still owed",
               idle_cycles, expected_points.size());
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_range_in   <= '0;
    in_column_in  <= '0;
    in_last_point <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= '0;
    cfg_wdata     <= '0;
    idle_cycles   <= 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_scans();
    test_register_settings();
    test_random_scans();
    test_output_backpressure();
    test_sender_pause();
    test_long_scan();

    $display("Run covered %0d scans, %0d points, %0d register settings, one %0d-point scan",
             scans_sent, points_sent, settings_used, LONG_SCAN_LEN);
    $display("Checked %0d results with output hold-off and mid-scan pauses; %0d mismatches",
             results_seen, mismatches);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
